/* rtl/core/frac_n_divider_calculator_assert.svh */
// Assertion macros for the frac-N divider calculator checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FRAC_N_DIVIDER_CALCULATOR_ASSERT_SVH
`define FRAC_N_DIVIDER_CALCULATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define FND_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define FND_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fnd_pkg.sv */
// Shared widths, band table, lane types and division step for the
// frac-N divider calculator. No dependencies.
`timescale 1ns / 1ps

package fnd_pkg;

  localparam int PFD_W    = 28;
  localparam int MOD_W    = 12;
  localparam int FREQ_W   = 33;
  localparam int E_W      = 3;
  localparam int DINT_W   = 16;
  localparam int SCALED_W = 40;
  localparam int DIV_W    = PFD_W + 1;   // partial remainder / divisor width
  localparam int PROD_W   = PFD_W + MOD_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam int INT_STAGES  = DINT_W / 2;  // two quotient bits per stage
  localparam int FRAC_STAGES = MOD_W / 2;
  localparam int FRAC_LAT    = FRAC_STAGES + 2;

  localparam int NUM_BANDS = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PFD_HZ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b1;

  localparam logic [PFD_W-1:0]  PFD_RESET = 28'd10000000;
  localparam logic [MOD_W-1:0]  MOD_RESET = 12'd4000;
  localparam logic [DINT_W-1:0] DINT_MAX  = 16'hFFFF;

  localparam logic [FREQ_W-1:0] BAND_FLOOR [NUM_BANDS] = '{
    33'd3000000000, 33'd1500000000, 33'd750000000, 33'd375000000,
    33'd187500000,  33'd93750000,   33'd46875000
  };

  typedef struct packed {
    logic [DIV_W-1:0]  rem;
    logic [DINT_W-1:0] low;
    logic [DINT_W-1:0] quo;
    logic [E_W-1:0]    e;
    logic              ovf;
  } int_lane_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [MOD_W-1:0] low;
    logic [MOD_W-1:0] quo;
  } frac_lane_t;

  typedef struct packed {
    logic [DINT_W-1:0] quo;
    logic [E_W-1:0]    e;
    logic              ovf;
  } side_t;

  typedef struct packed {
    logic en;
    logic valid;
  } frac_ctrl_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic b,
                                              input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    t    = {rem, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[DIV_W-1:0]};
    end else begin
      return {1'b0, t[DIV_W-1:0]};
    end
  endfunction

endpackage

/* rtl/core/fnd_frac_unit.sv */
// Fraction numerator pipeline: remainder times modulus, then a pipelined
// round-half-up division by the phase detector frequency. Uses fnd_pkg.
`timescale 1ns / 1ps

module fnd_frac_unit import fnd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frac_ctrl_t        ctrl_i,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [PFD_W-1:0]  pfd_i,
  input  logic [MOD_W-1:0]  mod_i,
  output logic              valid_o,
  output logic [MOD_W-1:0]  num_o
);

  logic [PROD_W-1:0] prod_q;
  logic              prod_vld_q;
  logic [NUM_W-1:0]  n_sum;
  logic [DIV_W-1:0]  dvsr;

  frac_lane_t lane_q   [FRAC_STAGES+1];
  logic       lvld_q   [FRAC_STAGES+1];

  assign dvsr  = {pfd_i, 1'b0};
  assign n_sum = {prod_q, 1'b0} + NUM_W'(pfd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      lvld_q[0]  <= 1'b0;
    end else if (ctrl_i.en) begin
      prod_vld_q <= ctrl_i.valid;
      lvld_q[0]  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q        <= rem_i[PFD_W-1:0] * mod_i;
      lane_q[0].rem <= n_sum[NUM_W-1 -: DIV_W];
      lane_q[0].low <= n_sum[MOD_W-1:0];
      lane_q[0].quo <= '0;
    end
  end

  for (genvar k = 0; k < FRAC_STAGES; k++) begin : g_fdiv
    logic [DIV_W:0] s1;
    logic [DIV_W:0] s2;
    frac_lane_t     nxt;

    always_comb begin
      s1 = div_step(lane_q[k].rem, lane_q[k].low[MOD_W-1], dvsr);
      s2 = div_step(s1[DIV_W-1:0], lane_q[k].low[MOD_W-2], dvsr);
      nxt.rem = s2[DIV_W-1:0];
      nxt.low = {lane_q[k].low[MOD_W-3:0], 2'b00};
      nxt.quo = {lane_q[k].quo[MOD_W-3:0], s1[DIV_W], s2[DIV_W]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lvld_q[k+1] <= 1'b0;
      end else if (ctrl_i.en) begin
        lvld_q[k+1] <= lvld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        lane_q[k+1] <= nxt;
      end
    end
  end

  assign valid_o = lvld_q[FRAC_STAGES];
  assign num_o   = lane_q[FRAC_STAGES].quo;

endmodule

/* rtl/core/frac_n_divider_calculator.sv */
// Top level of the frac-N divider calculator: band select, overflow test,
// pipelined integer division, fraction path and output stage. Uses fnd_pkg, fnd_frac_unit.
`timescale 1ns / 1ps

// Usage:
//   Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at once
//   (0 = pfd_hz, 1 = modulus). Write only while no word is in flight.
//   Input: one freq_hz word per valid/ready handshake.
//   Output: divider_integer, fraction_numerator, output_divider_log2 and
//   overflow, one word per input word, in order.
//   Pipeline from accept to out_valid_o: band select and shift, overflow
//   compare, integer division at two quotient bits per stage, multiply,
//   rounding sum, fraction division at two bits per stage, carry/saturate.
//   Throughput: one word per cycle unless stalled; all stages registered.
//   Stall: the whole pipeline holds while out_valid_o is high and
//   out_ready_i is low; in_ready_o drops in that case, nothing is lost.
//   Reset: valid bits clear, pfd_hz returns to 10 MHz, modulus to 4000.

module frac_n_divider_calculator import fnd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PFD_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FREQ_W-1:0]    freq_hz_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DINT_W-1:0]    divider_integer_o,
  output logic [MOD_W-1:0]     fraction_numerator_o,
  output logic [E_W-1:0]       output_divider_log2_o,
  output logic                 overflow_o
);

  logic [PFD_W-1:0] pfd_q;
  logic [MOD_W-1:0] mod_q;
  logic [PFD_W-1:0] pfd_eff;
  logic             en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pfd_q <= PFD_RESET;
      mod_q <= MOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PFD_HZ:  pfd_q <= cfg_wdata_i;
        REG_MODULUS: mod_q <= cfg_wdata_i[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign pfd_eff    = (pfd_q == '0) ? PFD_W'(1) : pfd_q;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage A: band select and shift
  logic [E_W-1:0]      band;
  logic [SCALED_W-1:0] scaled_q;
  logic [E_W-1:0]      ea_q;
  logic                va_q;

  always_comb begin
    band = E_W'(NUM_BANDS);
    for (int k = NUM_BANDS - 1; k >= 0; k--) begin
      if (freq_hz_i >= BAND_FLOOR[k]) band = E_W'(k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scaled_q <= SCALED_W'(freq_hz_i) << band;
      ea_q     <= band;
    end
  end

  // stage B: quotient fits 16 bits unless scaled >= pfd * 2^16
  int_lane_t lane_q [INT_STAGES+1];
  logic      lvld_q [INT_STAGES+1];
  logic      ovf_b;
  logic [DIV_W-1:0] dvsr;

  assign dvsr  = {1'b0, pfd_eff};
  assign ovf_b = {(PFD_W + DINT_W - SCALED_W)'(0), scaled_q} >= {pfd_eff, DINT_W'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvld_q[0] <= 1'b0;
    end else if (en) begin
      lvld_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_q[0].rem <= DIV_W'(scaled_q[SCALED_W-1:DINT_W]);
      lane_q[0].low <= scaled_q[DINT_W-1:0];
      lane_q[0].quo <= '0;
      lane_q[0].e   <= ea_q;
      lane_q[0].ovf <= ovf_b;
    end
  end

  // integer division, two bits per stage; remainder stays below pfd unless ovf is set
  for (genvar k = 0; k < INT_STAGES; k++) begin : g_idiv
    logic [DIV_W:0] s1;
    logic [DIV_W:0] s2;
    int_lane_t      nxt;

    always_comb begin
      s1 = div_step(lane_q[k].rem, lane_q[k].low[DINT_W-1], dvsr);
      s2 = div_step(s1[DIV_W-1:0], lane_q[k].low[DINT_W-2], dvsr);
      nxt.rem = s2[DIV_W-1:0];
      nxt.low = {lane_q[k].low[DINT_W-3:0], 2'b00};
      nxt.quo = {lane_q[k].quo[DINT_W-3:0], s1[DIV_W], s2[DIV_W]};
      nxt.e   = lane_q[k].e;
      nxt.ovf = lane_q[k].ovf;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lvld_q[k+1] <= 1'b0;
      end else if (en) begin
        lvld_q[k+1] <= lvld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        lane_q[k+1] <= nxt;
      end
    end
  end

  // fraction path, with the integer result delayed alongside
  frac_ctrl_t       fctrl;
  logic             fvalid;
  logic [MOD_W-1:0] fnum;
  side_t            side_q [FRAC_LAT];

  assign fctrl.en    = en;
  assign fctrl.valid = lvld_q[INT_STAGES];

  fnd_frac_unit u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fctrl),
    .rem_i   (lane_q[INT_STAGES].rem),
    .pfd_i   (pfd_eff),
    .mod_i   (mod_q),
    .valid_o (fvalid),
    .num_o   (fnum)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].quo <= lane_q[INT_STAGES].quo;
      side_q[0].e   <= lane_q[INT_STAGES].e;
      side_q[0].ovf <= lane_q[INT_STAGES].ovf;
      for (int k = 1; k < FRAC_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // output stage: carry of a numerator that rounded up to the modulus,
  // then saturation
  side_t             last;
  logic              carry;
  logic [DINT_W:0]   q_sum;
  logic [DINT_W-1:0] dint_d;
  logic [MOD_W-1:0]  num_d;
  logic              ovf_d;
  logic              out_valid_q;
  logic [DINT_W-1:0] dint_q;
  logic [MOD_W-1:0]  num_q;
  logic [E_W-1:0]    e_q;
  logic              ovf_q;

  assign last = side_q[FRAC_LAT-1];

  always_comb begin
    carry  = (mod_q != '0) && (fnum >= mod_q);
    num_d  = (mod_q == '0 || carry) ? '0 : fnum;
    q_sum  = {1'b0, last.quo} + (DINT_W + 1)'(carry);
    dint_d = q_sum[DINT_W-1:0];
    ovf_d  = last.ovf || q_sum[DINT_W];
    if (ovf_d) begin
      dint_d = DINT_MAX;
      num_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dint_q <= dint_d;
      num_q  <= num_d;
      e_q    <= last.e;
      ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign divider_integer_o     = dint_q;
  assign fraction_numerator_o  = num_q;
  assign output_divider_log2_o = e_q;
  assign overflow_o            = ovf_q;

endmodule

/* rtl/core/fnd_checker.sv */
// Port-level checker for the frac-N divider calculator, bound to the top.
// Uses fnd_pkg and frac_n_divider_calculator_assert.svh.
`timescale 1ns / 1ps
`include "frac_n_divider_calculator_assert.svh"

module fnd_checker import fnd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [DINT_W-1:0]    divider_integer_o,
  input logic [MOD_W-1:0]     fraction_numerator_o,
  input logic [E_W-1:0]       output_divider_log2_o,
  input logic                 overflow_o
);

  // pipeline advances exactly when the output slot frees up
  `FND_ASSERT(a_ready_follows_out, in_ready_o == (!out_valid_o || out_ready_i), "ready mismatch")

  // saturated word carries no fraction
  `FND_ASSERT_IMPL(a_ovf_sat, out_valid_o && overflow_o, divider_integer_o == DINT_MAX && fraction_numerator_o == '0, "overflow word not saturated")

  // numerator stays below the largest modulus
  `FND_ASSERT_IMPL(a_num_range, out_valid_o, fraction_numerator_o != {MOD_W{1'b1}}, "numerator out of range")

  // stalled output word holds
  `FND_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(divider_integer_o) && $stable(fraction_numerator_o) && $stable(overflow_o), "stalled word changed")

  `FND_ASSERT_NEXT(a_band_hold, out_valid_o && !out_ready_i, $stable(output_divider_log2_o), "stalled band changed")

endmodule

bind frac_n_divider_calculator fnd_checker u_fnd_checker (.*);
